// File: rtl/core/rfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_pkg
// Shared types, sizes and the CRC-24Q byte update for the frame synchronizer.
// ----------------------------------------------------------------------------
package rfs_pkg;

  localparam int PEND_AW     = 11;                 // hold buffer address bits
  localparam int PEND_DEPTH  = 1 << PEND_AW;
  localparam int PAY_AW      = 10;                 // payload store address bits
  localparam int PAY_DEPTH   = 1 << PAY_AW;
  localparam int IDX_W       = 11;                 // offset into a candidate frame
  localparam int CNT_W       = PEND_AW + 1;

  localparam logic [7:0]  PREAMBLE = 8'hD3;
  localparam logic [23:0] CRC_POLY = 24'h864CFB;   // x^24 term implied

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic [PAY_AW-1:0] index;
  } cmd_t;

  // Advance the CRC-24Q by one byte, MSB first.
  function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      c = c[23] ? ({c[22:0], 1'b0} ^ CRC_POLY) : {c[22:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/rfs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/rfs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_front
// Input side: takes words, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module rfs_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      opcode_i,
  input  logic [7:0]                stream_byte_i,
  input  logic [rfs_pkg::PAY_AW-1:0] read_index_i,
  output logic                      cmd_valid_o,
  output rfs_pkg::cmd_t             cmd_o,
  input  logic                      cmd_take_i
);

  rfs_pkg::cmd_t slot_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          enq, deq;
  rfs_pkg::cmd_t cmd_in;

  // Classify the incoming word
  always_comb begin
    cmd_in.op    = opcode_i ? rfs_pkg::OP_READ : rfs_pkg::OP_PUSH;
    cmd_in.data  = stream_byte_i;
    cmd_in.index = read_index_i;
  end

  assign full_o      = (cnt_q == 2'd2);
  assign enq         = push_i && !full_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign deq         = cmd_take_i && cmd_valid_o;
  assign cmd_o       = slot_q[rptr_q];

  // Hold queued words
  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wptr_q] <= cmd_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (enq) wptr_q <= ~wptr_q;
      if (deq) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
    end
  end

endmodule

// File: rtl/core/rfs_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_engine
// Back side: holds stream bytes, hunts frames, checks CRC, keeps the payload.
// ----------------------------------------------------------------------------
module rfs_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  rfs_pkg::cmd_t              cmd_i,
  output logic                       cmd_take_o,
  output logic                       empty_o,
  input  logic                       pop_i,
  output logic [7:0]                 read_byte_o,
  output logic [7:0]                 good_frames_new_o,
  output logic [10:0]                bad_frames_new_o,
  output logic [11:0]                latest_type_o,
  output logic [rfs_pkg::PAY_AW-1:0] latest_length_o,
  output logic [31:0]                good_total_o,
  output logic [31:0]                bad_total_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_RDWAIT, S_SCAN, S_CHK, S_HDR1, S_HDR2, S_BODY
  } state_e;

  localparam int AW = rfs_pkg::PEND_AW;
  localparam int CW = rfs_pkg::CNT_W;
  localparam int PW = rfs_pkg::PAY_AW;
  localparam int IW = rfs_pkg::IDX_W;

  state_e          state_q;
  logic [AW-1:0]   head_q, tail_q;
  logic [CW-1:0]   cnt_q;
  logic [IW-1:0]   idx_q;
  logic [PW-1:0]   plen_q;
  logic [7:0]      h1_q;
  logic [23:0]     crc_q, got_q;
  logic [11:0]     type_q;
  logic            bank_q;
  logic [PW-1:0]   len_q;
  logic [11:0]     ltype_q;
  logic [31:0]     gtot_q, btot_q;
  logic [7:0]      gnew_q;
  logic [10:0]     bnew_q;
  logic            out_valid_q;
  logic [7:0]      out_rd_q, out_gnew_q;
  logic [10:0]     out_bnew_q;
  logic [11:0]     out_type_q;
  logic [PW-1:0]   out_len_q;
  logic [31:0]     out_gtot_q, out_btot_q;

  logic            out_free;
  logic            pend_we;
  logic [AW-1:0]   pend_raddr;
  logic [7:0]      pend_rdata;
  logic            pay_we;
  logic [PW:0]     pay_waddr, pay_raddr;
  logic [7:0]      pay_rdata;
  logic [PW-1:0]   plen_hdr;
  logic [IW-1:0]   body_end, pay_end;
  logic [IW-1:0]   pay_off;

  assign out_free   = !out_valid_q || pop_i;
  assign cmd_take_o = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign pend_we    = cmd_take_o && (cmd_i.op == rfs_pkg::OP_PUSH) &&
                      (cnt_q < CW'(rfs_pkg::PEND_DEPTH));
  assign plen_hdr   = {h1_q[1:0], pend_rdata};
  assign pay_end    = IW'(plen_q) + IW'(3);
  assign body_end   = IW'(plen_q) + IW'(5);
  assign pay_off    = idx_q - IW'(3);
  assign pay_we     = (state_q == S_BODY) && (idx_q < pay_end);
  assign pay_waddr  = {~bank_q, pay_off[PW-1:0]};
  assign pay_raddr  = {bank_q, cmd_i.index};

  // Select the hold buffer read address for the next step
  always_comb begin
    pend_raddr = head_q;
    unique case (state_q)
      S_CHK:   pend_raddr = head_q + AW'(1);
      S_HDR1:  pend_raddr = head_q + AW'(2);
      S_HDR2:  pend_raddr = head_q + AW'(3);
      S_BODY:  pend_raddr = head_q + AW'(idx_q + IW'(1));
      default: pend_raddr = head_q;
    endcase
  end

  rfs_ram #(.Width(8), .Depth(rfs_pkg::PEND_DEPTH)) u_pend (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.data),
    .raddr_i (pend_raddr),
    .rdata_o (pend_rdata)
  );

  // Two payload banks: one readable, one filled by the frame under check
  rfs_ram #(.Width(8), .Depth(2 * rfs_pkg::PAY_DEPTH)) u_pay (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (pend_rdata),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  // Sequencer, frame state, counters and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      len_q       <= '0;
      ltype_q     <= '0;
      gtot_q      <= '0;
      btot_q      <= '0;
      gnew_q      <= '0;
      bnew_q      <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      plen_q      <= '0;
      h1_q        <= '0;
      crc_q       <= '0;
      got_q       <= '0;
      type_q      <= '0;
      out_rd_q    <= '0;
      out_gnew_q  <= '0;
      out_bnew_q  <= '0;
      out_type_q  <= '0;
      out_len_q   <= '0;
      out_gtot_q  <= '0;
      out_btot_q  <= '0;
    end else begin
      if (pop_i && out_valid_q && !cmd_take_o) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_take_o) begin
            gnew_q <= '0;
            bnew_q <= '0;
            if (cmd_i.op == rfs_pkg::OP_READ) begin
              if (cmd_i.index < len_q) begin
                out_valid_q <= 1'b0;
                state_q     <= S_RDWAIT;
              end else begin
                out_valid_q <= 1'b1;
                out_rd_q    <= '0;
                out_gnew_q  <= '0;
                out_bnew_q  <= '0;
                out_type_q  <= ltype_q;
                out_len_q   <= len_q;
                out_gtot_q  <= gtot_q;
                out_btot_q  <= btot_q;
              end
            end else begin
              out_valid_q <= 1'b0;
              if (pend_we) begin
                tail_q <= tail_q + AW'(1);
                cnt_q  <= cnt_q + CW'(1);
              end
              state_q <= S_SCAN;
            end
          end
        end
        S_RDWAIT: begin
          out_valid_q <= 1'b1;
          out_rd_q    <= pay_rdata;
          out_gnew_q  <= '0;
          out_bnew_q  <= '0;
          out_type_q  <= ltype_q;
          out_len_q   <= len_q;
          out_gtot_q  <= gtot_q;
          out_btot_q  <= btot_q;
          state_q     <= S_IDLE;
        end
        S_SCAN: begin
          if (cnt_q == '0) begin
            out_valid_q <= 1'b1;
            out_rd_q    <= '0;
            out_gnew_q  <= gnew_q;
            out_bnew_q  <= bnew_q;
            out_type_q  <= ltype_q;
            out_len_q   <= len_q;
            out_gtot_q  <= gtot_q;
            out_btot_q  <= btot_q;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (pend_rdata != rfs_pkg::PREAMBLE) begin
            // drop a byte that cannot open a frame
            head_q  <= head_q + AW'(1);
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_SCAN;
          end else if (cnt_q < CW'(3)) begin
            out_valid_q <= 1'b1;
            out_rd_q    <= '0;
            out_gnew_q  <= gnew_q;
            out_bnew_q  <= bnew_q;
            out_type_q  <= ltype_q;
            out_len_q   <= len_q;
            out_gtot_q  <= gtot_q;
            out_btot_q  <= btot_q;
            state_q     <= S_IDLE;
          end else begin
            crc_q   <= rfs_pkg::crc_byte(24'h000000, pend_rdata);
            state_q <= S_HDR1;
          end
        end
        S_HDR1: begin
          h1_q    <= pend_rdata;
          crc_q   <= rfs_pkg::crc_byte(crc_q, pend_rdata);
          state_q <= S_HDR2;
        end
        S_HDR2: begin
          if ((CW'(plen_hdr) + CW'(6)) > cnt_q) begin
            // frame not complete yet: wait for more bytes
            out_valid_q <= 1'b1;
            out_rd_q    <= '0;
            out_gnew_q  <= gnew_q;
            out_bnew_q  <= bnew_q;
            out_type_q  <= ltype_q;
            out_len_q   <= len_q;
            out_gtot_q  <= gtot_q;
            out_btot_q  <= btot_q;
            state_q     <= S_IDLE;
          end else begin
            plen_q  <= plen_hdr;
            crc_q   <= rfs_pkg::crc_byte(crc_q, pend_rdata);
            idx_q   <= IW'(3);
            state_q <= S_BODY;
          end
        end
        S_BODY: begin
          if (idx_q < pay_end) begin
            crc_q <= rfs_pkg::crc_byte(crc_q, pend_rdata);
            if (idx_q == IW'(3)) type_q[11:4] <= pend_rdata;
            if (idx_q == IW'(4)) type_q[3:0]  <= pend_rdata[7:4];
          end else begin
            got_q <= {got_q[15:0], pend_rdata};
          end
          if (idx_q == body_end) begin
            if ({got_q[15:0], pend_rdata} == crc_q) begin
              gtot_q  <= gtot_q + 32'd1;
              gnew_q  <= gnew_q + 8'd1;
              bank_q  <= ~bank_q;
              len_q   <= plen_q;
              ltype_q <= (plen_q < PW'(2)) ? 12'h000 : type_q;
              head_q  <= head_q + AW'(CW'(plen_q) + CW'(6));
              cnt_q   <= cnt_q - (CW'(plen_q) + CW'(6));
            end else begin
              btot_q <= btot_q + 32'd1;
              bnew_q <= bnew_q + 11'd1;
              head_q <= head_q + AW'(1);
              cnt_q  <= cnt_q - CW'(1);
            end
            state_q <= S_SCAN;
          end else begin
            idx_q <= idx_q + IW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign empty_o           = !out_valid_q;
  assign read_byte_o       = out_rd_q;
  assign good_frames_new_o = out_gnew_q;
  assign bad_frames_new_o  = out_bnew_q;
  assign latest_type_o     = out_type_q;
  assign latest_length_o   = out_len_q;
  assign good_total_o      = out_gtot_q;
  assign bad_total_o       = out_btot_q;

endmodule

// File: rtl/core/rtcm3_frame_sync_crc24q.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcm3_frame_sync_crc24q
// Frame synchronizer with CRC-24Q check for a serial correction byte stream.
// ----------------------------------------------------------------------------
// Input channel: a queue interface (push / full). Each word either pushes
// a stream byte (opcode 0) or reads a byte of the latest good payload
// (opcode 1). A two-word queue decouples the input from the engine.
// Result channel: a queue interface (empty / pop), one result per word,
// held in an output register that stays stable until popped.
// Sequence, from the accepting edge with the engine idle: a read past the
// payload is answered straight from the idle state, a read inside it waits
// for the registered payload read. A push enters the engine; the hunt then
// drops held bytes that cannot open a frame, stops when the hold buffer is
// empty or holds a preamble whose frame is still incomplete, and checks each
// complete candidate through its header and body states; a CRC failure
// restarts the hunt one byte later over the held bytes. The registered hold
// buffer read port sets the pace of each step. The engine works on one word at
// a time and takes the next once its result register is free.
// Reset clears counters, pointers and the latest frame info; buffer contents
// are not cleared. When the receiver stalls, the engine holds its finished
// result and stops; the input queue then fills and full rises.
// ----------------------------------------------------------------------------
module rtcm3_frame_sync_crc24q (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        opcode_i,
  input  logic [7:0]  stream_byte_i,
  input  logic [9:0]  read_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  read_byte_o,
  output logic [7:0]  good_frames_new_o,
  output logic [10:0] bad_frames_new_o,
  output logic [11:0] latest_type_o,
  output logic [9:0]  latest_length_o,
  output logic [31:0] good_total_o,
  output logic [31:0] bad_total_o
);

  logic          cmd_valid;
  logic          cmd_take;
  rfs_pkg::cmd_t cmd;

  rfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .opcode_i      (opcode_i),
    .stream_byte_i (stream_byte_i),
    .read_index_i  (read_index_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_take_i    (cmd_take)
  );

  rfs_engine u_engine (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (cmd_valid),
    .cmd_i             (cmd),
    .cmd_take_o        (cmd_take),
    .empty_o           (empty),
    .pop_i             (pop),
    .read_byte_o       (read_byte_o),
    .good_frames_new_o (good_frames_new_o),
    .bad_frames_new_o  (bad_frames_new_o),
    .latest_type_o     (latest_type_o),
    .latest_length_o   (latest_length_o),
    .good_total_o      (good_total_o),
    .bad_total_o       (bad_total_o)
  );

endmodule

// File: rtl/core/rfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfs_checker
// Port-level checks for the frame synchronizer, bound to the top level.
// ----------------------------------------------------------------------------
module rfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  read_byte_o,
  input logic [11:0] latest_type_o,
  input logic [9:0]  latest_length_o,
  input logic [31:0] good_total_o
);

  // Hold a waiting word until it is popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(good_total_o) && $stable(read_byte_o))
    else $error("result word changed while waiting");

  // Report type zero for payloads under two bytes
  a_short_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && latest_length_o < 10'd2 |-> latest_type_o == 12'h000)
    else $error("message type set for short payload");

  // Read nothing from an empty payload
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && latest_length_o == 10'd0 |-> read_byte_o == 8'h00)
    else $error("payload byte returned with no payload");

  // Keep length zero until a good frame has been seen
  a_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && good_total_o == 32'd0 |-> latest_length_o == 10'd0)
    else $error("payload length set without a good frame");

endmodule

bind rtcm3_frame_sync_crc24q rfs_checker u_rfs_checker (.*);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives push and read words into the RTCM3 frame synchronizer, predicts each
// result from a behavioral copy of the frame hunt and CRC-24Q check, and
// compares every popped result field by field.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HOLD_DEPTH    = 2048;
  localparam int STALL_LIMIT   = 20000;
  localparam int WORD_TARGET   = 750;

  typedef struct {
    logic [7:0]  rd;
    logic [7:0]  gnew;
    logic [10:0] bnew;
    logic [11:0] mtype;
    logic [9:0]  mlen;
    logic [31:0] gtot;
    logic [31:0] btot;
  } frame_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        opcode_i = 1'b0;
  logic [7:0]  stream_byte_i = '0;
  logic [9:0]  read_index_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  read_byte_o;
  logic [7:0]  good_frames_new_o;
  logic [10:0] bad_frames_new_o;
  logic [11:0] latest_type_o;
  logic [9:0]  latest_length_o;
  logic [31:0] good_total_o;
  logic [31:0] bad_total_o;

  rtcm3_frame_sync_crc24q u_dut (
    .clk_i, .rst_ni, .push, .full, .opcode_i, .stream_byte_i, .read_index_i,
    .empty, .pop, .read_byte_o, .good_frames_new_o, .bad_frames_new_o,
    .latest_type_o, .latest_length_o, .good_total_o, .bad_total_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  logic [7:0]  hold_mem [HOLD_DEPTH];
  int unsigned hold_head, hold_cnt;
  logic [7:0]  payload_mem [1024];
  logic [9:0]  lat_len;
  logic [11:0] lat_type;
  logic [31:0] good_cnt, bad_cnt;

  frame_result_t expected_q[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          sent_count = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %0t %s: got %0h want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic logic [7:0] held(input int unsigned k);
    return hold_mem[(hold_head + k) % HOLD_DEPTH];
  endfunction

  function automatic logic [23:0] crc24q_step(input logic [23:0] c_in, input logic [7:0] b);
    logic [23:0] c;
    c = c_in ^ {b, 16'h0};
    for (int i = 0; i < 8; i++) c = c[23] ? ({c[22:0], 1'b0} ^ 24'h864CFB) : {c[22:0], 1'b0};
    return c;
  endfunction

  // Compute the expected result of one word and advance predictor state
  function automatic frame_result_t predict_sync(input rfs_pkg::op_e op, input logic [7:0] b,
                                                 input logic [9:0] idx);
    frame_result_t r;
    int unsigned plen;
    logic [23:0] calc, got;
    logic [7:0]  hb1, hb4;
    r = '{default: '0};
    if (op == rfs_pkg::OP_READ) begin
      if (idx < lat_len) r.rd = payload_mem[idx];
    end else begin
      if (hold_cnt < HOLD_DEPTH) begin
        hold_mem[(hold_head + hold_cnt) % HOLD_DEPTH] = b;
        hold_cnt++;
      end
      forever begin
        while (hold_cnt > 0 && held(0) != rfs_pkg::PREAMBLE) begin
          hold_head = (hold_head + 1) % HOLD_DEPTH;
          hold_cnt--;
        end
        if (hold_cnt < 3) break;
        hb1 = held(1);
        plen = {hb1[1:0], held(2)};
        if (plen + 6 > hold_cnt) break;
        got = {held(3 + plen), held(4 + plen), held(5 + plen)};
        calc = '0;
        for (int unsigned k = 0; k < 3 + plen; k++) calc = crc24q_step(calc, held(k));
        if (got == calc) begin
          good_cnt++;
          r.gnew++;
          for (int unsigned k = 0; k < plen; k++) payload_mem[k] = held(3 + k);
          lat_len = 10'(plen);
          hb4 = held(4);
          lat_type = (plen < 2) ? 12'h0 : {held(3), hb4[7:4]};
          hold_head = (hold_head + plen + 6) % HOLD_DEPTH;
          hold_cnt -= plen + 6;
        end else begin
          bad_cnt++;
          r.bnew++;
          hold_head = (hold_head + 1) % HOLD_DEPTH;
          hold_cnt--;
        end
      end
    end
    r.mtype = lat_type;
    r.mlen = lat_len;
    r.gtot = good_cnt;
    r.btot = bad_cnt;
    return r;
  endfunction

  // Send one word, with bursty random gaps before it
  int burst_left = 0;
  task automatic send_word(input rfs_pkg::op_e op, input logic [7:0] b, input logic [9:0] idx);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    opcode_i <= op;
    stream_byte_i <= b;
    read_index_i <= idx;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sent_count++;
    expected_q.insert(expected_q.size(), predict_sync(op, b, idx));
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_word(rfs_pkg::OP_PUSH, b, 10'($urandom()));
  endtask

  task automatic read_byte(input logic [9:0] idx);
    send_word(rfs_pkg::OP_READ, 8'($urandom()), idx);
  endtask

  // Push a whole frame; corrupt flips one CRC bit
  task automatic push_frame(input int unsigned plen, input bit corrupt);
    logic [7:0]  body [$];
    logic [23:0] c;
    body = {rfs_pkg::PREAMBLE, {6'($urandom()), 2'(plen >> 8)}, 8'(plen)};
    for (int unsigned k = 0; k < plen; k++) body = {body, 8'($urandom())};
    c = '0;
    foreach (body[k]) c = crc24q_step(c, body[k]);
    if (corrupt) c ^= 24'(1) << $urandom_range(0, 23);
    body = {body, c[23:16], c[15:8], c[7:0]};
    foreach (body[k]) push_byte(body[k]);
  endtask

  task automatic read_payload();
    for (int k = 0; k <= lat_len && k < 1024; k++) read_byte(10'(k));
  endtask

  // Directed: short payloads, extremes of bytes and indexes, bad CRC replay
  task automatic test_directed();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_frame(0, 1'b0);
    push_frame(1, 1'b0);
    read_byte(10'd0);
    read_byte(10'h3FF);
    push_frame(2, 1'b0);
    push_frame(3, 1'b1);
    push_frame(4, 1'b0);
    read_payload();
  endtask

  // Good frame hidden inside a bad candidate, found on replay
  task automatic test_replay();
    push_byte(rfs_pkg::PREAMBLE);
    push_byte(8'h00);
    push_byte(8'h05);
    push_frame(0, 1'b0);
    push_frame(5, 1'b0);
    read_payload();
  endtask

  // Long payload once, reading its far end and just past it
  task automatic test_long_frame();
    push_frame(384, 1'b0);
    read_byte(10'd383);
    read_byte(10'd384);
    read_byte(10'($urandom()));
  endtask

  // Random mix: mostly well-formed frames, some noise and broken frames
  task automatic test_random();
    while (sent_count < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          push_byte(8'($urandom()));
        end
        2: begin
          read_byte(10'($urandom()));
        end
        3: begin
          push_frame($urandom_range(0, 12), 1'b1);
        end
        4: begin
          read_byte(10'($urandom_range(0, 15)));
        end
        default: begin
          push_frame($urandom_range(0, 20), 1'b0);
        end
      endcase
    end
  endtask

  // Receiver stall pattern and result check
  always @(posedge clk_i) begin
    frame_result_t e;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 32'd0, 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (read_byte_o !== e.rd) report("read_byte", 32'(read_byte_o), 32'(e.rd));
          if (good_frames_new_o !== e.gnew)
            report("good_new", 32'(good_frames_new_o), 32'(e.gnew));
          if (bad_frames_new_o !== e.bnew)
            report("bad_new", 32'(bad_frames_new_o), 32'(e.bnew));
          if (latest_type_o !== e.mtype)
            report("latest_type", 32'(latest_type_o), 32'(e.mtype));
          if (latest_length_o !== e.mlen)
            report("latest_length", 32'(latest_length_o), 32'(e.mlen));
          if (good_total_o !== e.gtot) report("good_total", good_total_o, e.gtot);
          if (bad_total_o !== e.btot) report("bad_total", bad_total_o, e.btot);
        end
      end
      pop <= ($urandom_range(0, 3) != 0) || ((($time / 10000) % 2) == 0);
    end
  end

  // Watchdog on cycles with no accepted word on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    hold_head = 0;
    hold_cnt = 0;
    lat_len = '0;
    lat_type = '0;
    good_cnt = '0;
    bad_cnt = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_replay();
    test_long_frame();
    test_random();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
